>>> hdl/ljpf_pkg.sv
`default_nettype none

package ljpf_pkg;

	localparam int MAX_PARTICLES_DEF = 64;

	localparam int POS_W     = 24;
	localparam int FRC_W     = 32;
	localparam int IDX_W     = 6;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_BOX   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd2;

	localparam logic [22:0]        BOX_RST   = 23'd655360;
	localparam logic [30:0]        CUT_RST   = 31'd1327104;
	localparam logic signed [17:0] SHIFT_RST = -18'sd32;

	// Q.32 magnitudes, capped at 2^63
	localparam logic [63:0] CAP       = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
	localparam logic [63:0] HALF_Q32  = 64'h0000_0000_8000_0000;
	localparam logic [63:0] CAP_DIV48 = CAP / 64'd48;
	localparam logic [63:0] CAP_DIV4  = CAP / 64'd4;

	// a separation component first, a signed force term later
	typedef logic signed [33:0] lane_t;

endpackage

`default_nettype wire

>>> hdl/lennard_jones_pair_forces_core.sv
`default_nettype none

// Lennard-Jones pair force engine. Positions are loaded one per cycle with start while busy
// is low; the beat marked last starts a run. The run clears the force store (one entry per
// cycle), then walks every pair on one 32x32 multiplier and one 1-bit-per-cycle divider:
// every pair takes three 25-step wrap divisions (when the box size is nonzero), and an
// interacting pair adds a 64-step reciprocal and eight 4-product multiplies. Results then
// come out one at a time, with a wait state between them, each marked by strobe for one
// cycle; there is no way to hold them off, so the receiver must take every beat. busy falls
// with the last result.
module lennard_jones_pair_forces_core #(
	parameter int MAX_PARTICLES = ljpf_pkg::MAX_PARTICLES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_x,
	input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_y,
	input  wire logic signed [ljpf_pkg::POS_W-1:0]     pos_z,
	input  wire logic                                  last,
	input  wire logic                                  cfg_we,
	input  wire logic [ljpf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ljpf_pkg::CFG_W-1:0]            cfg_data,
	output logic                                       strobe,
	output logic [ljpf_pkg::IDX_W-1:0]                 particle_index,
	output logic signed [ljpf_pkg::FRC_W-1:0]          force_x,
	output logic signed [ljpf_pkg::FRC_W-1:0]          force_y,
	output logic signed [ljpf_pkg::FRC_W-1:0]          force_z,
	output logic signed [ljpf_pkg::FRC_W-1:0]          total_energy,
	output logic                                       overflow,
	output logic                                       last_result
);

	localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int XW = CW + 1;

	localparam int SW = 5;
	localparam logic [SW-1:0] S_IDLE  = 5'd0;
	localparam logic [SW-1:0] S_CLR   = 5'd1;
	localparam logic [SW-1:0] S_RD    = 5'd2;
	localparam logic [SW-1:0] S_DIFF  = 5'd3;
	localparam logic [SW-1:0] S_DIVW  = 5'd4;
	localparam logic [SW-1:0] S_WRAP  = 5'd5;
	localparam logic [SW-1:0] S_SQ    = 5'd6;
	localparam logic [SW-1:0] S_CHK   = 5'd7;
	localparam logic [SW-1:0] S_DIVR  = 5'd8;
	localparam logic [SW-1:0] S_RECIP = 5'd9;
	localparam logic [SW-1:0] S_MUL   = 5'd10;
	localparam logic [SW-1:0] S_POST  = 5'd11;
	localparam logic [SW-1:0] S_FWI   = 5'd12;
	localparam logic [SW-1:0] S_FWJ   = 5'd13;
	localparam logic [SW-1:0] S_NEXT  = 5'd14;
	localparam logic [SW-1:0] S_OWAIT = 5'd15;
	localparam logic [SW-1:0] S_OUT   = 5'd16;

	// which step of the pair chain a finished multiply belongs to
	localparam logic [2:0] T_R4  = 3'd0;
	localparam logic [2:0] T_R6  = 3'd1;
	localparam logic [2:0] T_R8  = 3'd2;
	localparam logic [2:0] T_FF  = 3'd3;
	localparam logic [2:0] T_EN  = 3'd4;
	localparam logic [2:0] T_FRC = 3'd5;

	localparam logic [6:0] WRAP_STEPS  = 7'd25;
	localparam logic [6:0] RECIP_STEPS = 7'd64;

	// control
	logic [SW-1:0]        st_q;
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;
	logic [IW-1:0]        ii_q, jj_q;
	logic [1:0]           ax_q;
	logic [2:0]           ms_q;
	logic [2:0]           tag_q;
	logic [6:0]           div_cnt_q;
	logic                 strobe_q;
	logic [22:0]          box_q;
	logic [30:0]          cut_q;
	logic signed [17:0]   shift_q;

	// datapath
	logic [71:0]          pos_mem [MAX_PARTICLES];
	logic [71:0]          pa_q, pb_q;
	logic [95:0]          frc_mem [MAX_PARTICLES];
	logic [95:0]          fa_q, fb_q;
	ljpf_pkg::lane_t      lane_q [3];
	logic [49:0]          rem_q, den_q;
	logic [63:0]          quo_q;
	logic [63:0]          prod_q, acc_q, opa_q, opb_q, r2i_q, r6i_q, ff_q;
	logic [49:0]          r2_q;
	logic signed [31:0]   energy_q;
	logic [ljpf_pkg::IDX_W-1:0] idx_q;
	logic signed [31:0]   fx_q, fy_q, fz_q, en_q;
	logic                 ovo_q, lst_q;

	logic [XW-1:0] ii_x, jj_x, n_x;
	logic          ii_more, jj_more, ii2_more;
	logic          load_ok;

	assign ii_x     = XW'(ii_q);
	assign jj_x     = XW'(jj_q);
	assign n_x      = XW'(cnt_q);
	assign ii_more  = (ii_x + XW'(1)) < n_x;
	assign jj_more  = (jj_x + XW'(1)) < n_x;
	assign ii2_more = (ii_x + XW'(2)) < n_x;
	assign load_ok  = cnt_q < CW'(MAX_PARTICLES);
	assign busy     = st_q != S_IDLE;

	// separation along the current axis
	logic [23:0]        pa_ax, pb_ax;
	logic signed [24:0] d_c;
	logic [24:0]        m_c;

	always_comb begin
		case (ax_q)
			2'd0: begin
				pa_ax = pa_q[23:0];
				pb_ax = pb_q[23:0];
			end
			2'd1: begin
				pa_ax = pa_q[47:24];
				pb_ax = pb_q[47:24];
			end
			default: begin
				pa_ax = pa_q[71:48];
				pb_ax = pb_q[71:48];
			end
		endcase
	end

	assign d_c = $signed({pa_ax[23], pa_ax}) - $signed({pb_ax[23], pb_ax});
	assign m_c = d_c[24] ? 25'(-d_c) : 25'(d_c);

	// restoring divider, one quotient bit per cycle
	logic [50:0] rem_sh;
	logic        rem_ge;
	logic [49:0] rem_nx;
	logic [63:0] quo_nx;

	assign rem_sh = {rem_q, quo_q[63]};
	assign rem_ge = rem_sh >= {1'b0, den_q};
	assign rem_nx = rem_ge ? 50'(rem_sh - {1'b0, den_q}) : rem_sh[49:0];
	assign quo_nx = {quo_q[62:0], rem_ge};

	// minimum image: round the quotient to nearest, ties to even
	logic [22:0]        r_w;
	logic               w_inc;
	logic signed [24:0] w_mag, w_c;

	assign r_w   = rem_q[22:0];
	assign w_inc = ({r_w, 1'b0} > {1'b0, box_q}) || (({r_w, 1'b0} == {1'b0, box_q}) && quo_q[0]);
	assign w_mag = w_inc ? ($signed({2'b0, r_w}) - $signed({2'b0, box_q})) : $signed({2'b0, r_w});
	assign w_c   = d_c[24] ? -w_mag : w_mag;

	logic [31:0] ad0, ad1;
	assign ad0 = lane_q[0][33] ? 32'(-lane_q[0]) : 32'(lane_q[0]);
	assign ad1 = lane_q[1][33] ? 32'(-lane_q[1]) : 32'(lane_q[1]);

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_c;

	always_comb begin
		if (st_q == S_SQ) begin
			mul_a = ad0;
			mul_b = ad0;
		end else begin
			case (ms_q)
				3'd0: begin
					mul_a = opa_q[63:32];
					mul_b = opb_q[63:32];
				end
				3'd1: begin
					mul_a = opa_q[63:32];
					mul_b = opb_q[31:0];
				end
				3'd2: begin
					mul_a = opa_q[31:0];
					mul_b = opb_q[63:32];
				end
				default: begin
					mul_a = opa_q[31:0];
					mul_b = opb_q[31:0];
				end
			endcase
		end
	end

	assign prod_c = mul_a * mul_b;

	// Q.32 product assembly from the four partial products, capped
	logic [63:0] acc_y, acc_nx;
	logic [64:0] acc_sum;
	logic        acc_cap;

	always_comb begin
		acc_y   = prod_q;
		acc_nx  = acc_q;
		acc_cap = 1'b0;
		if (ms_q == 3'd4)
			acc_y = {32'b0, prod_q[63:32]};
		acc_sum = {1'b0, acc_q} + {1'b0, acc_y};
		if (ms_q == 3'd1) begin
			if (prod_q >= ljpf_pkg::HALF_Q32) begin
				acc_nx  = ljpf_pkg::CAP;
				acc_cap = 1'b1;
			end else begin
				acc_nx = {prod_q[31:0], 32'b0};
			end
		end else if (ms_q != 3'd0) begin
			if (acc_sum > {1'b0, ljpf_pkg::CAP}) begin
				acc_nx  = ljpf_pkg::CAP;
				acc_cap = 1'b1;
			end else begin
				acc_nx = acc_sum[63:0];
			end
		end
	end

	logic        in_cut;
	logic [63:0] r2i_c;
	logic        ffneg, eneg;
	logic [63:0] t_c, em_c;
	logic        cap48, cap4;
	logic [63:0] ff_c, a4_c;

	assign in_cut = r2_q < {3'b0, cut_q, 16'b0};
	assign r2i_c  = (quo_q > ljpf_pkg::CAP) ? ljpf_pkg::CAP : quo_q;
	assign ffneg  = r6i_q < ljpf_pkg::HALF_Q32;
	assign t_c    = ffneg ? (ljpf_pkg::HALF_Q32 - r6i_q) : (r6i_q - ljpf_pkg::HALF_Q32);
	assign eneg   = r6i_q < ljpf_pkg::ONE_Q32;
	assign em_c   = eneg ? (ljpf_pkg::ONE_Q32 - r6i_q) : (r6i_q - ljpf_pkg::ONE_Q32);
	assign cap48  = acc_q > ljpf_pkg::CAP_DIV48;
	assign ff_c   = cap48 ? ljpf_pkg::CAP : ((acc_q << 5) + (acc_q << 4));
	assign cap4   = acc_q > ljpf_pkg::CAP_DIV4;
	assign a4_c   = cap4 ? ljpf_pkg::CAP : (acc_q << 2);

	// shifted pair energy into the saturating sum
	logic [47:0]        e_mag;
	logic signed [49:0] pe, pair;
	logic signed [50:0] esum;
	logic signed [31:0] en_c;
	logic               en_sat;

	assign e_mag = a4_c[63:16];
	assign pe    = eneg ? -$signed({2'b0, e_mag}) : $signed({2'b0, e_mag});
	assign pair  = pe - 50'(shift_q);
	assign esum  = 51'(energy_q) + 51'(pair);

	always_comb begin
		en_sat = 1'b1;
		if (esum > 51'sd2147483647)
			en_c = 32'sh7FFF_FFFF;
		else if (esum < -51'sd2147483648)
			en_c = 32'sh8000_0000;
		else begin
			en_c   = esum[31:0];
			en_sat = 1'b0;
		end
	end

	// force term for the current axis
	logic [32:0]     c_c;
	ljpf_pkg::lane_t v_c;

	assign c_c = (acc_q > ljpf_pkg::ONE_Q32) ? ljpf_pkg::ONE_Q32[32:0] : acc_q[32:0];
	assign v_c = (ffneg ^ lane_q[0][33]) ? -$signed({1'b0, c_c}) : $signed({1'b0, c_c});

	// saturating force updates, i gets +v and j gets -v
	logic [95:0] fi_new, fj_new;
	logic [2:0]  sat_i, sat_j;

	always_comb begin
		logic signed [34:0] si, sj;
		for (int a = 0; a < 3; a++) begin
			si = 35'($signed(fa_q[32*a +: 32])) + 35'(lane_q[a]);
			sj = 35'($signed(fb_q[32*a +: 32])) - 35'(lane_q[a]);
			sat_i[a] = 1'b1;
			sat_j[a] = 1'b1;
			if (si > 35'sd2147483647)
				fi_new[32*a +: 32] = 32'h7FFF_FFFF;
			else if (si < -35'sd2147483648)
				fi_new[32*a +: 32] = 32'h8000_0000;
			else begin
				fi_new[32*a +: 32] = si[31:0];
				sat_i[a] = 1'b0;
			end
			if (sj > 35'sd2147483647)
				fj_new[32*a +: 32] = 32'h7FFF_FFFF;
			else if (sj < -35'sd2147483648)
				fj_new[32*a +: 32] = 32'h8000_0000;
			else begin
				fj_new[32*a +: 32] = sj[31:0];
				sat_j[a] = 1'b0;
			end
		end
	end

	logic          f_we;
	logic [IW-1:0] f_addr;
	logic [95:0]   f_data;

	always_comb begin
		f_we   = 1'b0;
		f_addr = ii_q;
		f_data = '0;
		if (st_q == S_CLR) begin
			f_we = 1'b1;
		end else if (st_q == S_FWI) begin
			f_we   = 1'b1;
			f_data = fi_new;
		end else if (st_q == S_FWJ) begin
			f_we   = 1'b1;
			f_addr = jj_q;
			f_data = fj_new;
		end
	end

	logic ovf_set;

	assign ovf_set = ((st_q == S_IDLE) && start && !load_ok)
		|| ((st_q == S_CHK) && in_cut && (r2_q == '0))
		|| ((st_q == S_RECIP) && (quo_q > ljpf_pkg::CAP))
		|| ((st_q == S_MUL) && acc_cap)
		|| ((st_q == S_POST) && (tag_q == T_FF) && cap48)
		|| ((st_q == S_POST) && (tag_q == T_EN) && (cap4 || en_sat))
		|| ((st_q == S_FWI) && (sat_i != 3'b0))
		|| ((st_q == S_FWJ) && (sat_j != 3'b0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			ii_q      <= '0;
			jj_q      <= '0;
			ax_q      <= '0;
			ms_q      <= '0;
			tag_q     <= T_R4;
			div_cnt_q <= '0;
			strobe_q  <= 1'b0;
			box_q     <= ljpf_pkg::BOX_RST;
			cut_q     <= ljpf_pkg::CUT_RST;
			shift_q   <= ljpf_pkg::SHIFT_RST;
		end else begin
			strobe_q <= 1'b0;
			if (ovf_set)
				ovf_q <= 1'b1;
			if (cfg_we) begin
				unique case (cfg_index)
					ljpf_pkg::CFG_BOX:   box_q   <= cfg_data[22:0];
					ljpf_pkg::CFG_CUT:   cut_q   <= cfg_data[30:0];
					ljpf_pkg::CFG_SHIFT: shift_q <= $signed(cfg_data[17:0]);
					default: ;
				endcase
			end
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						if (load_ok)
							cnt_q <= cnt_q + CW'(1);
						if (last) begin
							ii_q <= '0;
							st_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					if (ii_more) begin
						ii_q <= ii_q + IW'(1);
					end else begin
						ii_q <= '0;
						if (cnt_q >= CW'(2)) begin
							jj_q <= IW'(1);
							st_q <= S_RD;
						end else begin
							st_q <= S_OWAIT;
						end
					end
				end
				S_RD: begin
					ax_q <= '0;
					st_q <= S_DIFF;
				end
				S_DIFF: begin
					if (box_q == '0) begin
						if (ax_q == 2'd2) begin
							ms_q <= '0;
							st_q <= S_SQ;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end else begin
						div_cnt_q <= WRAP_STEPS;
						st_q      <= S_DIVW;
					end
				end
				S_DIVW: begin
					div_cnt_q <= div_cnt_q - 7'd1;
					if (div_cnt_q == 7'd1)
						st_q <= S_WRAP;
				end
				S_WRAP: begin
					if (ax_q == 2'd2) begin
						ms_q <= '0;
						st_q <= S_SQ;
					end else begin
						ax_q <= ax_q + 2'd1;
						st_q <= S_DIFF;
					end
				end
				S_SQ: begin
					ms_q <= ms_q + 3'd1;
					if (ms_q == 3'd3)
						st_q <= S_CHK;
				end
				S_CHK: begin
					if (!in_cut || (r2_q == '0)) begin
						st_q <= S_NEXT;
					end else begin
						div_cnt_q <= RECIP_STEPS;
						st_q      <= S_DIVR;
					end
				end
				S_DIVR: begin
					div_cnt_q <= div_cnt_q - 7'd1;
					if (div_cnt_q == 7'd1)
						st_q <= S_RECIP;
				end
				S_RECIP: begin
					tag_q <= T_R4;
					ms_q  <= '0;
					st_q  <= S_MUL;
				end
				S_MUL: begin
					ms_q <= ms_q + 3'd1;
					if (ms_q == 3'd4)
						st_q <= S_POST;
				end
				S_POST: begin
					ms_q <= '0;
					st_q <= S_MUL;
					unique case (tag_q)
						T_R4: tag_q <= T_R6;
						T_R6: tag_q <= T_R8;
						T_R8: tag_q <= T_FF;
						T_FF: tag_q <= T_EN;
						T_EN: begin
							ax_q  <= '0;
							tag_q <= T_FRC;
						end
						T_FRC: begin
							if (ax_q == 2'd2)
								st_q <= S_FWI;
							else
								ax_q <= ax_q + 2'd1;
						end
						default: st_q <= S_IDLE;
					endcase
				end
				S_FWI: st_q <= S_FWJ;
				S_FWJ: st_q <= S_NEXT;
				S_NEXT: begin
					if (jj_more) begin
						jj_q <= jj_q + IW'(1);
						st_q <= S_RD;
					end else if (ii2_more) begin
						ii_q <= ii_q + IW'(1);
						jj_q <= IW'(ii_x + XW'(2));
						st_q <= S_RD;
					end else begin
						ii_q <= '0;
						st_q <= S_OWAIT;
					end
				end
				S_OWAIT: st_q <= S_OUT;
				S_OUT: begin
					strobe_q <= 1'b1;
					if (ii_more) begin
						ii_q <= ii_q + IW'(1);
						st_q <= S_OWAIT;
					end else begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						st_q  <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pa_q   <= pos_mem[ii_q];
		pb_q   <= pos_mem[jj_q];
		fa_q   <= frc_mem[ii_q];
		fb_q   <= frc_mem[jj_q];
		prod_q <= prod_c;
		if ((st_q == S_IDLE) && start && load_ok)
			pos_mem[cnt_q[IW-1:0]] <= {pos_z, pos_y, pos_x};
		if (f_we)
			frc_mem[f_addr] <= f_data;
		case (st_q)
			S_CLR: energy_q <= '0;
			S_RD: r2_q <= '0;
			S_DIFF: begin
				if (box_q == '0) begin
					lane_q[0] <= lane_q[1];
					lane_q[1] <= lane_q[2];
					lane_q[2] <= 34'(d_c);
				end else begin
					rem_q <= '0;
					den_q <= 50'(box_q);
					quo_q <= {m_c, 39'b0};
				end
			end
			S_DIVW, S_DIVR: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
			S_WRAP: begin
				lane_q[0] <= lane_q[1];
				lane_q[1] <= lane_q[2];
				lane_q[2] <= 34'(w_c);
			end
			S_SQ: begin
				if (ms_q != 3'd3) begin
					lane_q[0] <= lane_q[1];
					lane_q[1] <= lane_q[2];
					lane_q[2] <= lane_q[0];
				end
				if (ms_q != 3'd0)
					r2_q <= r2_q + prod_q[49:0];
			end
			S_CHK: begin
				rem_q <= '0;
				den_q <= r2_q;
				quo_q <= '1;
			end
			S_RECIP: begin
				r2i_q <= r2i_c;
				opa_q <= r2i_c;
				opb_q <= r2i_c;
			end
			S_MUL: begin
				if (ms_q != 3'd0)
					acc_q <= acc_nx;
			end
			S_POST: begin
				case (tag_q)
					T_R4: begin
						opa_q <= acc_q;
						opb_q <= r2i_q;
					end
					T_R6: begin
						r6i_q <= acc_q;
						opa_q <= r2i_q;
						opb_q <= acc_q;
					end
					T_R8: begin
						opa_q <= acc_q;
						opb_q <= t_c;
					end
					T_FF: begin
						ff_q  <= ff_c;
						opa_q <= r6i_q;
						opb_q <= em_c;
					end
					T_EN: begin
						energy_q <= en_c;
						opa_q    <= ff_q;
						opb_q    <= {32'b0, ad0};
					end
					default: begin
						// force term replaces the separation it came from
						lane_q[0] <= lane_q[1];
						lane_q[1] <= lane_q[2];
						lane_q[2] <= v_c;
						opa_q     <= ff_q;
						opb_q     <= {32'b0, ad1};
					end
				endcase
			end
			S_OUT: begin
				idx_q <= ljpf_pkg::IDX_W'(ii_q);
				fx_q  <= $signed(fa_q[31:0]);
				fy_q  <= $signed(fa_q[63:32]);
				fz_q  <= $signed(fa_q[95:64]);
				en_q  <= ii_more ? 32'sd0 : energy_q;
				ovo_q <= ovf_q;
				lst_q <= !ii_more;
			end
			default: ;
		endcase
	end

	assign strobe         = strobe_q;
	assign particle_index = idx_q;
	assign force_x        = fx_q;
	assign force_y        = fy_q;
	assign force_z        = fz_q;
	assign total_energy   = en_q;
	assign overflow       = ovo_q;
	assign last_result    = lst_q;

endmodule

`default_nettype wire
